[sv/fbjp_pkg.sv]
// ----------------------------------------------------------------------------
// fbjp_pkg
// Request and response types and codes for the job placer core.
// ----------------------------------------------------------------------------
package fbjp_pkg;

   localparam int unsigned FIELD_W = 16;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_PLACE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [FIELD_W-1:0] machine_id;
      logic [FIELD_W-1:0] total_cpu;
      logic [FIELD_W-1:0] total_mem;
      logic [FIELD_W-1:0] free_cpu;
      logic [FIELD_W-1:0] free_mem;
      logic [FIELD_W-1:0] need_cpu;
      logic [FIELD_W-1:0] need_mem;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] out_id;
      logic [FIELD_W-1:0] out_free_cpu;
      logic [FIELD_W-1:0] out_free_mem;
      logic               was_updated;
      logic               fully_idle;
      logic               last;
   } rsp_type;

   function automatic rsp_type status_only(input logic [1:0] status);
      rsp_type r;
      r = '0;
      r.status = status;
      r.last   = 1'b1;
      return r;
   endfunction

endpackage

[sv/fbjp_ram.sv]
// ----------------------------------------------------------------------------
// fbjp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbjp_ram #(
   parameter int unsigned WIDTH = 80,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/fit_based_job_placer_core.sv]
// ----------------------------------------------------------------------------
// fit_based_job_placer_core
// Machine table with first-fit / next-fit job placement and full readout.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  carries
//  request   req_valid req_stall req_data   in         op and entry/job fields
//  response  rsp_valid rsp_stall rsp_data   out        status, entry, last mark
//  config    csr_wr_en csr_wr_data          in         strategy mode bit
//
//  One request at a time. Clear and load go from decode straight to emit.
//  Place scans the table RAM one entry per cycle.
//  Readout reads each entry, captures it, then pushes it to the output while
//  the next RAM read issues; a stalled response holds the readout.
//  Synchronous reset empties the table and clears every touched mark at once.
//  A stalled response holds in its register; the next request is taken while
//  the final response of the previous one waits.
// ----------------------------------------------------------------------------
module fit_based_job_placer_core #(
   parameter int unsigned MAX_MACHINES = 16,
   parameter int unsigned CAP_WIDTH    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fbjp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fbjp_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   import fbjp_pkg::*;

   localparam int unsigned SW = (CAP_WIDTH < FIELD_W) ? CAP_WIDTH : FIELD_W;
   localparam int unsigned RW = FIELD_W + 4 * SW;
   localparam int unsigned CW = $clog2(MAX_MACHINES + 1);
   localparam int unsigned IW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_RD_WAIT,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           pend_ff, pend_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     start_ff, start_in;
   logic              mode_ff, mode_in;
   logic [MAX_MACHINES-1:0] touched_ff, touched_in;
   logic [IW-1:0]     addr_ff, addr_in;
   logic [CW-1:0]     issued_ff, issued_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [IW-1:0]     chk_addr_ff, chk_addr_in;
   logic              chk_last_ff, chk_last_in;

   logic              ram_we;
   logic [IW-1:0]     ram_waddr;
   logic [RW-1:0]     ram_wdata;
   logic              ram_re;
   logic [IW-1:0]     ram_raddr;
   logic [RW-1:0]     ram_rdata;

   logic [FIELD_W-1:0] rd_id;
   logic [SW-1:0]      rd_tcpu, rd_tmem, rd_icpu, rd_imem;
   logic [SW-1:0]      new_icpu, new_imem;
   logic [SW-1:0]      ld_tcpu, ld_tmem, ld_icpu, ld_imem;
   logic [SW-1:0]      nd_cpu, nd_mem;
   logic               slot_free;
   logic               fits;
   logic [CW-1:0]      addr_next_ext;
   logic [IW-1:0]      addr_wrap;

   fbjp_ram #(
      .WIDTH(RW),
      .DEPTH(MAX_MACHINES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_id   = ram_rdata[RW-1 -: FIELD_W];
   assign rd_tcpu = ram_rdata[4*SW-1 -: SW];
   assign rd_tmem = ram_rdata[3*SW-1 -: SW];
   assign rd_icpu = ram_rdata[2*SW-1 -: SW];
   assign rd_imem = ram_rdata[SW-1:0];

   assign ld_tcpu = req_ff.total_cpu[SW-1:0];
   assign ld_tmem = req_ff.total_mem[SW-1:0];
   assign ld_icpu = req_ff.free_cpu[SW-1:0];
   assign ld_imem = req_ff.free_mem[SW-1:0];
   assign nd_cpu  = req_ff.need_cpu[SW-1:0];
   assign nd_mem  = req_ff.need_mem[SW-1:0];

   assign fits     = (nd_cpu <= rd_icpu) && (nd_mem <= rd_imem);
   assign new_icpu = rd_icpu - nd_cpu;
   assign new_imem = rd_imem - nd_mem;

   assign addr_next_ext = CW'(addr_ff) + CW'(1);
   assign addr_wrap     = (addr_next_ext == count_ff) ? '0 : addr_next_ext[IW-1:0];

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pend_in      = pend_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      count_in     = count_ff;
      start_in     = start_ff;
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      touched_in   = touched_ff;
      addr_in      = addr_ff;
      issued_in    = issued_ff;
      chk_valid_in = 1'b0;
      chk_addr_in  = chk_addr_ff;
      chk_last_in  = chk_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[IW-1:0];
      ram_wdata    = {req_ff.machine_id, ld_tcpu, ld_tmem, ld_icpu, ld_imem};
      ram_re       = 1'b0;
      ram_raddr    = addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_EMIT;
            unique case (req_ff.op)
               OP_CLEAR: begin
                  count_in   = '0;
                  start_in   = '0;
                  touched_in = '0;
                  pend_in    = status_only(ST_OK);
               end
               OP_LOAD: begin
                  if (count_ff == CW'(MAX_MACHINES)) begin
                     pend_in = status_only(ST_FULL);
                  end else begin
                     ram_we                        = 1'b1;
                     touched_in[count_ff[IW-1:0]]  = 1'b0;
                     count_in                      = count_ff + CW'(1);
                     pend_in              = status_only(ST_OK);
                     pend_in.out_id       = req_ff.machine_id;
                     pend_in.out_free_cpu = FIELD_W'(ld_icpu);
                     pend_in.out_free_mem = FIELD_W'(ld_imem);
                     pend_in.fully_idle   = (ld_icpu == ld_tcpu) && (ld_imem == ld_tmem);
                  end
               end
               OP_PLACE: begin
                  if (count_ff == '0) begin
                     pend_in = status_only(ST_EMPTY);
                  end else begin
                     addr_in   = (mode_ff && (CW'(start_ff) < count_ff)) ? start_ff : '0;
                     issued_in = '0;
                     state_in  = S_SCAN;
                  end
               end
               OP_READ: begin
                  if (count_ff == '0) begin
                     pend_in = status_only(ST_EMPTY);
                  end else begin
                     addr_in   = '0;
                     ram_re    = 1'b1;
                     ram_raddr = '0;
                     state_in  = S_RD_WAIT;
                  end
               end
               default: begin
                  pend_in = status_only(ST_OK);
               end
            endcase
         end
         S_SCAN: begin
            if (chk_valid_ff && fits) begin
               // write back the reduced idle capacity and report the entry
               ram_we                  = 1'b1;
               ram_waddr               = chk_addr_ff;
               ram_wdata               = {rd_id, rd_tcpu, rd_tmem, new_icpu, new_imem};
               touched_in[chk_addr_ff] = 1'b1;
               start_in                = chk_addr_ff;
               pend_in                 = status_only(ST_OK);
               pend_in.out_id          = rd_id;
               pend_in.out_free_cpu    = FIELD_W'(new_icpu);
               pend_in.out_free_mem    = FIELD_W'(new_imem);
               pend_in.was_updated     = 1'b1;
               pend_in.fully_idle      = (new_icpu == rd_tcpu) && (new_imem == rd_tmem);
               state_in                = S_EMIT;
            end else if (chk_valid_ff && chk_last_ff) begin
               pend_in  = status_only(ST_NOFIT);
               state_in = S_EMIT;
            end else if (issued_ff != count_ff) begin
               // issue the next read while the previous entry is checked
               ram_re       = 1'b1;
               chk_valid_in = 1'b1;
               chk_addr_in  = addr_ff;
               chk_last_in  = (issued_ff + CW'(1)) == count_ff;
               issued_in    = issued_ff + CW'(1);
               addr_in      = addr_wrap;
            end
         end
         S_RD_WAIT: begin
            pend_in              = status_only(ST_OK);
            pend_in.out_id       = rd_id;
            pend_in.out_free_cpu = FIELD_W'(rd_icpu);
            pend_in.out_free_mem = FIELD_W'(rd_imem);
            pend_in.was_updated  = touched_ff[addr_ff];
            pend_in.fully_idle   = (rd_icpu == rd_tcpu) && (rd_imem == rd_tmem);
            pend_in.last         = (addr_next_ext == count_ff);
            state_in             = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
               if (pend_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  addr_in   = addr_next_ext[IW-1:0];
                  ram_re    = 1'b1;
                  ram_raddr = addr_next_ext[IW-1:0];
                  state_in  = S_RD_WAIT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         start_ff     <= '0;
         mode_ff      <= 1'b0;
         touched_ff   <= '0;
         issued_ff    <= '0;
         chk_valid_ff <= 1'b0;
         chk_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         mode_ff      <= mode_in;
         touched_ff   <= touched_in;
         issued_ff    <= issued_in;
         chk_valid_ff <= chk_valid_in;
         chk_last_ff  <= chk_last_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      addr_ff     <= addr_in;
      chk_addr_ff <= chk_addr_in;
   end

endmodule
